FILE: rtl/atan2a_pkg.sv
// Shared constants and types for the atan2 approximation pipeline.
// Depends on nothing; every rtl file refers to it by scoped names.
package atan2a_pkg;

	// Field widths and fixed-point formats.
	localparam int INPUT_WIDTH     = 16;
	localparam int ANGLE_FRAC_BITS = 12;
	localparam int RATIO_FRAC_BITS = 15;
	localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

	// Magnitude of the numerator and the divisor both need one bit over the input.
	localparam int MAG_W = INPUT_WIDTH + 1;
	localparam int DEN_W = INPUT_WIDTH + 1;

	// The quotient magnitude never exceeds 2^RATIO_FRAC_BITS.
	localparam int QUO_W      = RATIO_FRAC_BITS + 1;
	localparam int DVD_W      = MAG_W + RATIO_FRAC_BITS;
	localparam int REM_INIT_W = DVD_W - QUO_W;

	// The divider retires this many quotient bits in each pipeline stage.
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

	// pi/4 in Q3.ANGLE_FRAC_BITS, rounded to nearest from pi * 2^60.
	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	localparam int          QP_SHIFT = 62 - ANGLE_FRAC_BITS;
	localparam logic [63:0] QUARTER_PI_WIDE =
		(PI_Q60 + (64'd1 << (QP_SHIFT - 1))) >> QP_SHIFT;

	localparam int C1_W   = ANGLE_FRAC_BITS;
	localparam int PROD_W = C1_W + QUO_W;
	localparam int TERM_W = PROD_W - RATIO_FRAC_BITS;

	localparam logic [C1_W-1:0]        C1        = C1_W'(QUARTER_PI_WIDE);
	localparam logic [ANGLE_WIDTH-1:0] C1_A      = ANGLE_WIDTH'(QUARTER_PI_WIDE);
	localparam logic [ANGLE_WIDTH-1:0] C2_A      = ANGLE_WIDTH'(3 * QUARTER_PI_WIDE);
	localparam logic [ANGLE_WIDTH-1:0] ANGLE_MAX = ANGLE_WIDTH'(4 * QUARTER_PI_WIDE);
	localparam logic [QUO_W-1:0]       QUO_MAX   = QUO_W'(1) << RATIO_FRAC_BITS;

	// Working set of one divider stage plus the sign flags that ride along.
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] low;
		logic [QUO_W-1:0] quo;
		logic             num_neg;
		logic             x_neg;
		logic             y_neg;
	} div_stage_t;

endpackage

FILE: rtl/atan2_approximation_top.sv
// Top level of the atan2 approximation: operand setup, pipelined divider and angle stages.
// Depends on atan2a_pkg for widths, constants and the divider stage type.

// The block takes one signed (x_value, y_value) request per cycle while in_stall is
// low and returns one Q3.12 angle in radians per request, in order, using the
// first-order self-normalizing atan2 approximation. A request passes through two
// operand setup stages, a restoring divider that retires two quotient bits per
// stage, a multiply stage, an angle stage and the output register. Throughput is
// one request per cycle while out_stall is low. When out_stall holds the result,
// the pipeline fills its empty stages first and raises in_stall only once every
// stage holds a request.
module atan2_approximation_top (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_stall,
	input  logic signed [atan2a_pkg::INPUT_WIDTH-1:0]    x_value,
	input  logic signed [atan2a_pkg::INPUT_WIDTH-1:0]    y_value,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic signed [atan2a_pkg::ANGLE_WIDTH-1:0]    angle
);

	localparam int W2 = atan2a_pkg::INPUT_WIDTH + 2;

	// Stage registers: s1 and dv_s[0] set up operands, the other dv_s[k] are divider
	// stages, sm holds the product, sa the unsigned angle and so the output.
	logic                                     vld_s1;
	logic signed [atan2a_pkg::INPUT_WIDTH-1:0] x_s1;
	logic [atan2a_pkg::MAG_W-1:0]             a_s1;
	logic                                     yneg_s1;

	logic                                     dv_vld_s [atan2a_pkg::DIV_STAGES+1];
	atan2a_pkg::div_stage_t                   dv_s     [atan2a_pkg::DIV_STAGES+1];

	logic                                     vld_sm;
	logic [atan2a_pkg::TERM_W-1:0]            term_sm;
	logic                                     numneg_sm;
	logic                                     xneg_sm;
	logic                                     yneg_sm;

	logic                                     vld_sa;
	logic [atan2a_pkg::ANGLE_WIDTH-1:0]       angle_sa;
	logic                                     yneg_sa;

	logic                                     vld_so;
	logic [atan2a_pkg::ANGLE_WIDTH-1:0]       angle_so;

	// Stage enables and combinational values.
	logic                                     en_s1;
	logic                                     dv_en [atan2a_pkg::DIV_STAGES+1];
	logic                                     en_sm;
	logic                                     en_sa;
	logic                                     en_so;
	logic [atan2a_pkg::MAG_W-1:0]             y_ext;
	logic [atan2a_pkg::MAG_W-1:0]             a_in;
	logic signed [W2-1:0]                     x_w;
	logic signed [W2-1:0]                     a_w;
	logic signed [W2-1:0]                     num_w;
	logic signed [W2-1:0]                     den_w;
	logic signed [W2-1:0]                     mag_w;
	logic [atan2a_pkg::DVD_W-1:0]             dividend;
	atan2a_pkg::div_stage_t                   dv_init;
	logic [atan2a_pkg::PROD_W-1:0]            prod;
	logic [atan2a_pkg::ANGLE_WIDTH-1:0]       term_ext;
	logic [atan2a_pkg::ANGLE_WIDTH-1:0]       base;
	logic [atan2a_pkg::ANGLE_WIDTH-1:0]       angle_mux;

	// Retire STEPS_PER_STAGE quotient bits by restoring division.
	function automatic atan2a_pkg::div_stage_t div_steps(input atan2a_pkg::div_stage_t d);
		atan2a_pkg::div_stage_t r;
		logic [atan2a_pkg::DEN_W+1:0] trial;
		logic                         ge;
		r = d;
		for (int i = 0; i < atan2a_pkg::STEPS_PER_STAGE; i++) begin
			trial = {1'b0, r.rem, r.low[atan2a_pkg::QUO_W-1]} - {2'b00, r.den};
			ge    = !trial[atan2a_pkg::DEN_W+1];
			if (ge) begin
				r.rem = trial[atan2a_pkg::DEN_W-1:0];
			end else begin
				r.rem = {r.rem[atan2a_pkg::DEN_W-2:0], r.low[atan2a_pkg::QUO_W-1]};
			end
			r.low = {r.low[atan2a_pkg::QUO_W-2:0], 1'b0};
			r.quo = {r.quo[atan2a_pkg::QUO_W-2:0], ge};
		end
		return r;
	endfunction

	// Each stage moves when it is empty or when the stage after it moves.
	always_comb begin
		en_so = !vld_so || !out_stall;
		en_sa = !vld_sa || en_so;
		en_sm = !vld_sm || en_sa;
		dv_en[atan2a_pkg::DIV_STAGES] = !dv_vld_s[atan2a_pkg::DIV_STAGES] || en_sm;
		for (int k = atan2a_pkg::DIV_STAGES - 1; k >= 0; k--) begin
			dv_en[k] = !dv_vld_s[k] || dv_en[k+1];
		end
		en_s1 = !vld_s1 || dv_en[0];
	end

	assign in_stall  = !en_s1;
	assign out_valid = vld_so;
	assign angle     = angle_so;

	// The divisor offset is |y| + 1, formed one bit wider so the most negative y fits.
	always_comb begin
		y_ext = {y_value[atan2a_pkg::INPUT_WIDTH-1], y_value};
		if (y_value[atan2a_pkg::INPUT_WIDTH-1]) begin
			a_in = ~y_ext + atan2a_pkg::MAG_W'(2);
		end else begin
			a_in = y_ext + atan2a_pkg::MAG_W'(1);
		end
	end

	// Numerator and divisor by quadrant, then the numerator magnitude and the
	// divider's starting remainder.
	always_comb begin
		x_w = W2'(x_s1);
		a_w = W2'(a_s1);
		if (x_s1[atan2a_pkg::INPUT_WIDTH-1]) begin
			num_w = x_w + a_w;
			den_w = a_w - x_w;
		end else begin
			num_w = x_w - a_w;
			den_w = x_w + a_w;
		end
		mag_w    = num_w[W2-1] ? -num_w : num_w;
		dividend = {mag_w[atan2a_pkg::MAG_W-1:0], {atan2a_pkg::RATIO_FRAC_BITS{1'b0}}};
		dv_init.rem = {{(atan2a_pkg::DEN_W - atan2a_pkg::REM_INIT_W){1'b0}},
			dividend[atan2a_pkg::DVD_W-1:atan2a_pkg::QUO_W]};
		dv_init.den     = den_w[atan2a_pkg::DEN_W-1:0];
		dv_init.low     = dividend[atan2a_pkg::QUO_W-1:0];
		dv_init.quo     = '0;
		dv_init.num_neg = num_w[W2-1];
		dv_init.x_neg   = x_s1[atan2a_pkg::INPUT_WIDTH-1];
		dv_init.y_neg   = yneg_s1;
	end

	// Scale the quotient magnitude by pi/4 and drop the ratio fraction bits.
	assign prod = atan2a_pkg::PROD_W'(atan2a_pkg::C1)
		* atan2a_pkg::PROD_W'(dv_s[atan2a_pkg::DIV_STAGES].quo);

	// Base angle by half plane, minus the signed correction term.
	always_comb begin
		term_ext = atan2a_pkg::ANGLE_WIDTH'(term_sm);
		base     = xneg_sm ? atan2a_pkg::C2_A : atan2a_pkg::C1_A;
		if (numneg_sm) begin
			angle_mux = base + term_ext;
		end else begin
			angle_mux = base - term_ext;
		end
	end

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k <= atan2a_pkg::DIV_STAGES; k++) begin
				dv_vld_s[k] <= 1'b0;
			end
			vld_sm <= 1'b0;
			vld_sa <= 1'b0;
			vld_so <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (dv_en[0]) begin
				dv_vld_s[0] <= vld_s1;
			end
			for (int k = 1; k <= atan2a_pkg::DIV_STAGES; k++) begin
				if (dv_en[k]) begin
					dv_vld_s[k] <= dv_vld_s[k-1];
				end
			end
			if (en_sm) begin
				vld_sm <= dv_vld_s[atan2a_pkg::DIV_STAGES];
			end
			if (en_sa) begin
				vld_sa <= vld_sm;
			end
			if (en_so) begin
				vld_so <= vld_sa;
			end
		end
	end

	// Payload of every stage, loaded under the same enables.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1    <= x_value;
			a_s1    <= a_in;
			yneg_s1 <= y_value[atan2a_pkg::INPUT_WIDTH-1];
		end
		if (dv_en[0]) begin
			dv_s[0] <= dv_init;
		end
		for (int k = 1; k <= atan2a_pkg::DIV_STAGES; k++) begin
			if (dv_en[k]) begin
				dv_s[k] <= div_steps(dv_s[k-1]);
			end
		end
		if (en_sm) begin
			term_sm   <= prod[atan2a_pkg::PROD_W-1:atan2a_pkg::RATIO_FRAC_BITS];
			numneg_sm <= dv_s[atan2a_pkg::DIV_STAGES].num_neg;
			xneg_sm   <= dv_s[atan2a_pkg::DIV_STAGES].x_neg;
			yneg_sm   <= dv_s[atan2a_pkg::DIV_STAGES].y_neg;
		end
		if (en_sa) begin
			angle_sa <= angle_mux;
			yneg_sa  <= yneg_sm;
		end
		if (en_so) begin
			angle_so <= yneg_sa ? -angle_sa : angle_sa;
		end
	end

	// The input is held off only when every stage is full and the output is stalled.
	a_full_before_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && vld_s1))
		else $error("input stalled while the pipeline still has an empty stage");

	// The finished quotient magnitude never exceeds one in Q1.15.
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[atan2a_pkg::DIV_STAGES]
		|-> (dv_s[atan2a_pkg::DIV_STAGES].quo <= atan2a_pkg::QUO_MAX))
		else $error("divider quotient above one");

	// The partial remainder stays below the divisor at the end of the divider.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[atan2a_pkg::DIV_STAGES]
		|-> (dv_s[atan2a_pkg::DIV_STAGES].rem < dv_s[atan2a_pkg::DIV_STAGES].den))
		else $error("divider remainder not below the divisor");

	// Results stay within plus or minus pi.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(angle) <= $signed(atan2a_pkg::ANGLE_MAX)
			&& $signed(angle) >= -$signed(atan2a_pkg::ANGLE_MAX)))
		else $error("angle outside plus or minus pi");

endmodule
